// ===== design/ute_pkg.sv =====
// Shared types and constants for the unicode escape translator.
package ute_pkg;

  // Held-byte store: the escape letter plus up to eight digits
  localparam int HELD_DEPTH = 10;
  localparam int IDX_W      = 4;

  localparam logic [31:0] CODE_LIMIT = 32'h0010_FFFF;

  localparam logic [IDX_W-1:0] NEED_NARROW = 4'd4;
  localparam logic [IDX_W-1:0] NEED_WIDE   = 4'd8;

  // Characters of interest
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_UP_U   = 8'h55;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_OPEN   = 8'h7B;
  localparam logic [7:0] CH_CLOSE  = 8'h7D;

  // Source of an output word
  typedef enum logic [2:0] {
    SEL_HELD  = 3'd0,
    SEL_BYTE  = 3'd1,
    SEL_X     = 3'd2,
    SEL_OPEN  = 3'd3,
    SEL_CLOSE = 3'd4
  } sel_t;

  // Controller to datapath
  typedef struct packed {
    logic             accept;
    logic             out_load;
    sel_t             sel;
    logic [IDX_W-1:0] idx;
    logic             mark_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             now_flush;
    logic             now_byte;
    logic             now_xlate;
    logic             byte_q;
    logic             last_q;
    logic [IDX_W-1:0] fcnt_q;
    logic [IDX_W-1:0] need_q;
    logic             out_free;
  } sts_t;

endpackage

// ===== design/ute_ctrl.sv =====
// Sequencer that turns one accepted byte into its run of output words.
module ute_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ute_pkg::sts_t sts,
  output ute_pkg::cmd_t cmd
);
  import ute_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FLUSH = 7'b0000010,
    S_BYTE  = 7'b0000100,
    S_XCH   = 7'b0001000,
    S_OPEN  = 7'b0010000,
    S_DIGIT = 7'b0100000,
    S_CLOSE = 7'b1000000
  } state_t;

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;

  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    cmd.accept    = 1'b0;
    cmd.out_load  = 1'b0;
    cmd.sel       = SEL_BYTE;
    cmd.idx       = idx;
    cmd.mark_last = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          idx_next   = '0;
          if (sts.now_flush) state_next = S_FLUSH;
          else if (sts.now_byte) state_next = S_BYTE;
          else if (sts.now_xlate) state_next = S_XCH;
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.sel       = SEL_HELD;
          cmd.mark_last = sts.last_q && !sts.byte_q && (idx == sts.fcnt_q);
          if (idx == sts.fcnt_q) state_next = sts.byte_q ? S_BYTE : S_IDLE;
          else idx_next = idx + 1'b1;
        end
      end
      S_BYTE: begin
        if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.sel       = SEL_BYTE;
          cmd.mark_last = sts.last_q;
          state_next    = S_IDLE;
        end
      end
      S_XCH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.sel      = SEL_X;
          state_next   = S_OPEN;
        end
      end
      S_OPEN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.sel      = SEL_OPEN;
          idx_next     = {{(IDX_W-1){1'b0}}, 1'b1};
          state_next   = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.sel      = SEL_HELD;
          if (idx == sts.need_q) state_next = S_CLOSE;
          else idx_next = idx + 1'b1;
        end
      end
      S_CLOSE: begin
        if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.sel       = SEL_CLOSE;
          cmd.mark_last = sts.last_q;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

// ===== design/ute_dp.sv =====
// Parser state, held escape bytes, word plan and output register.
module ute_dp (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  ute_pkg::cmd_t cmd,
  output ute_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_last,
  output logic          range_error
);
  import ute_pkg::*;

  typedef enum logic [2:0] {
    M_NORMAL  = 3'd0,
    M_PAREN   = 3'd1,
    M_PAREN_Q = 3'd2,
    M_COMMENT = 3'd3,
    M_ESCAPE  = 3'd4
  } mode_t;

  // Parser state
  mode_t            parse_mode, parse_mode_next;
  logic             slash_run_odd, slash_run_odd_next;
  logic             wide_escape, wide_escape_next;
  logic [IDX_W-1:0] digit_count, digit_count_next;
  logic [31:0]      code_accum, code_accum_next;
  logic             error_seen, error_seen_next;
  logic [7:0]       held_bytes [HELD_DEPTH];

  // Plan of the words owed for the accepted byte
  logic             byte_q, last_q, berr_q;
  logic [7:0]       bbyte_q;
  logic [IDX_W-1:0] fcnt_q, need_q;

  // Combinational plan and store write
  logic             p_flush, p_byte, p_xlate, p_berr;
  logic [7:0]       p_bbyte;
  logic [IDX_W-1:0] p_fcnt, need, dc_inc;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             hex_ok;
  logic [3:0]       hex_val;
  logic [31:0]      code_sh;
  logic             t_slash_in, t_slash, t_start;
  mode_t            t_mode_in, t_mode;

  // Hex digit decode
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) hex_val = 4'(in_byte - 8'h30);
    else if (in_byte >= 8'h61 && in_byte <= 8'h66) hex_val = 4'(in_byte - 8'h57);
    else if (in_byte >= 8'h41 && in_byte <= 8'h46) hex_val = 4'(in_byte - 8'h37);
    else hex_ok = 1'b0;
  end

  assign need    = wide_escape ? NEED_WIDE : NEED_NARROW;
  assign dc_inc  = digit_count + 1'b1;
  assign code_sh = {code_accum[27:0], hex_val};

  // Ordinary text handling; after a failed escape no backslash run is pending
  always_comb begin
    t_slash_in = (parse_mode == M_ESCAPE) ? 1'b0 : slash_run_odd;
    t_mode_in  = (parse_mode == M_ESCAPE) ? M_NORMAL : parse_mode;
    t_start    = t_slash_in && (in_byte == CH_LOW_U || in_byte == CH_UP_U);
    t_slash    = (in_byte == CH_BSLASH) ? ~t_slash_in : 1'b0;
    if (in_byte == CH_BSLASH) t_mode = M_NORMAL;
    else if (in_byte == CH_LPAREN) t_mode = M_PAREN;
    else if (t_mode_in == M_PAREN && in_byte == CH_QMARK) t_mode = M_PAREN_Q;
    else if (t_mode_in == M_PAREN_Q && in_byte == CH_HASH) t_mode = M_COMMENT;
    else t_mode = M_NORMAL;
  end

  // Parser step and word plan
  always_comb begin
    parse_mode_next    = parse_mode;
    slash_run_odd_next = slash_run_odd;
    wide_escape_next   = wide_escape;
    digit_count_next   = digit_count;
    code_accum_next    = code_accum;
    error_seen_next    = error_seen;
    wr_en   = 1'b0;
    wr_addr = '0;
    p_flush = 1'b0;
    p_byte  = 1'b0;
    p_xlate = 1'b0;
    p_berr  = 1'b0;
    p_bbyte = in_byte;
    p_fcnt  = digit_count;
    if (error_seen) begin
      if (in_last) begin
        p_byte  = 1'b1;
        p_bbyte = 8'h00;
        p_berr  = 1'b1;
      end
    end else if (parse_mode == M_COMMENT) begin
      p_byte = 1'b1;
      if (in_byte == CH_RPAREN) parse_mode_next = M_NORMAL;
    end else if (parse_mode == M_ESCAPE) begin
      if (!hex_ok) begin
        // Replay letter and digits, then the byte as text
        p_flush            = 1'b1;
        p_byte             = 1'b1;
        parse_mode_next    = t_mode;
        slash_run_odd_next = t_slash;
        digit_count_next   = '0;
        code_accum_next    = '0;
      end else begin
        wr_en            = 1'b1;
        wr_addr          = dc_inc;
        digit_count_next = dc_inc;
        code_accum_next  = code_sh;
        if (dc_inc >= need) begin
          if (code_sh > CODE_LIMIT) begin
            error_seen_next = 1'b1;
            p_byte          = 1'b1;
            p_bbyte         = 8'h00;
            p_berr          = 1'b1;
          end else begin
            p_xlate            = 1'b1;
            parse_mode_next    = M_NORMAL;
            slash_run_odd_next = 1'b0;
            digit_count_next   = '0;
            code_accum_next    = '0;
          end
        end else if (in_last) begin
          // Short escape at end of pattern
          p_flush = 1'b1;
          p_fcnt  = dc_inc;
        end
      end
    end else if (t_start) begin
      parse_mode_next  = M_ESCAPE;
      wide_escape_next = (in_byte == CH_UP_U);
      digit_count_next = '0;
      code_accum_next  = '0;
      wr_en            = 1'b1;
      wr_addr          = '0;
      if (in_last) begin
        p_flush = 1'b1;
        p_fcnt  = '0;
      end
    end else begin
      p_byte             = 1'b1;
      parse_mode_next    = t_mode;
      slash_run_odd_next = t_slash;
    end
    // End of pattern: back to the starting state
    if (in_last) begin
      parse_mode_next    = M_NORMAL;
      slash_run_odd_next = 1'b0;
      wide_escape_next   = 1'b0;
      digit_count_next   = '0;
      code_accum_next    = '0;
      error_seen_next    = 1'b0;
    end
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode    <= M_NORMAL;
      slash_run_odd <= 1'b0;
      wide_escape   <= 1'b0;
      digit_count   <= '0;
      code_accum    <= '0;
      error_seen    <= 1'b0;
    end else if (cmd.accept) begin
      parse_mode    <= parse_mode_next;
      slash_run_odd <= slash_run_odd_next;
      wide_escape   <= wide_escape_next;
      digit_count   <= digit_count_next;
      code_accum    <= code_accum_next;
      error_seen    <= error_seen_next;
    end
  end

  // Held bytes and plan registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (wr_en) held_bytes[wr_addr] <= in_byte;
      byte_q  <= p_byte;
      last_q  <= in_last;
      bbyte_q <= p_bbyte;
      berr_q  <= p_berr;
      fcnt_q  <= p_fcnt;
      need_q  <= need;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_last    <= cmd.mark_last;
      range_error <= 1'b0;
      case (cmd.sel)
        SEL_HELD:  out_byte <= held_bytes[cmd.idx];
        SEL_BYTE: begin
          out_byte    <= bbyte_q;
          range_error <= berr_q;
        end
        SEL_X:     out_byte <= CH_X;
        SEL_OPEN:  out_byte <= CH_OPEN;
        SEL_CLOSE: out_byte <= CH_CLOSE;
        default:   out_byte <= 8'h00;
      endcase
    end
  end

  // Status
  assign sts.now_flush = p_flush;
  assign sts.now_byte  = p_byte;
  assign sts.now_xlate = p_xlate;
  assign sts.byte_q    = byte_q;
  assign sts.last_q    = last_q;
  assign sts.fcnt_q    = fcnt_q;
  assign sts.need_q    = need_q;
  assign sts.out_free  = !out_valid || !out_stall;

endmodule

// ===== design/unicode_escape_translator_top.sv =====
// Top level of the unicode escape translator: controller, datapath, checks.
//
// Rewrites a pattern text byte by byte: a u after an odd backslash run with
// four hex digits, or a U with eight, leaves as x{digits}; all else passes
// through, and nothing is translated inside a (?# comment. A byte is taken
// in only while the controller's sequencer is idle; the sequencer then sends
// the words it causes one at a time through the single output register, and
// stall on the output holds them back. A plain byte gives one word, a byte
// that only extends an escape none, a completed escape up to eleven words,
// and a failed escape its held bytes and the byte. An escape above 0x10FFFF
// gives one word with range_error set; later bytes are dropped, and the last
// byte of the pattern gives one more error word with out_last set.
module unicode_escape_translator_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       range_error
);
  import ute_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ute_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ute_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .range_error (range_error)
  );

`ifndef SYNTHESIS
  // No word is sent while a new byte is taken in
  a_accept_no_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !cmd.out_load)
    else $error("output load during input accept");

  // A word is loaded only when the output register can take it
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten");

  // Error words carry a zero byte
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && range_error) |-> (out_byte == 8'h00))
    else $error("error word with non-zero byte");
`endif

endmodule

// ===== dv/unicode_escape_translator_top_tb.sv =====
// Self-checking testbench for the unicode escape translator top level.
module unicode_escape_translator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ute_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_LEN    = 300;
  localparam int DRAIN_LEN   = 40;

  typedef enum logic [2:0] {
    PM_TEXT,
    PM_PAREN,
    PM_PAREN_Q,
    PM_COMMENT,
    PM_ESCAPE
  } parse_mode_t;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } in_word_t;

  typedef struct {
    logic [7:0] b;
    logic       last;
    logic       err;
  } out_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       range_error;

  // words waiting to be offered, and translated words still due
  in_word_t  pend_words[$];
  out_word_t due_words[$];

  int send_gap_pct   = 35;
  int recv_stall_pct = 54;
  int hold_ticket    = 0;
  int hold_done;
  int hold_left;
  int n_fail = 0;
  int cycles = 0;

  // translator state as predicted
  parse_mode_t mode = PM_TEXT;
  logic        odd_run = 1'b0;
  logic        wide = 1'b0;
  logic [3:0]  ndig = '0;
  logic [7:0]  held [HELD_DEPTH];
  logic [31:0] acc = '0;
  logic        err_seen = 1'b0;

  unicode_escape_translator_top uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .range_error (range_error)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // watchdog
  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit up);
    if (n < 10) return "0" + n;
    return 8'((up ? "A" : "a") + n - 10);
  endfunction

  function automatic void due_word(input logic [7:0] b, input logic err);
    due_words.push_back('{b: b, last: 1'b0, err: err});
  endfunction

  function automatic void clear_state();
    mode     = PM_TEXT;
    odd_run  = 1'b0;
    wide     = 1'b0;
    ndig     = '0;
    acc      = '0;
    err_seen = 1'b0;
  endfunction

  // ordinary text: may open an escape, track backslash parity and comment opener
  function automatic void take_text(input logic [7:0] b);
    if (odd_run && (b == CH_LOW_U || b == CH_UP_U)) begin
      mode    = PM_ESCAPE;
      wide    = (b == CH_UP_U);
      ndig    = '0;
      acc     = '0;
      held[0] = b;
    end else begin
      due_word(b, 1'b0);
      if (b == CH_BSLASH) begin
        odd_run = ~odd_run;
        mode    = PM_TEXT;
      end else begin
        odd_run = 1'b0;
        if (b == CH_LPAREN) mode = PM_PAREN;
        else if (mode == PM_PAREN && b == CH_QMARK) mode = PM_PAREN_Q;
        else if (mode == PM_PAREN_Q && b == CH_HASH) mode = PM_COMMENT;
        else mode = PM_TEXT;
      end
    end
  endfunction

  // replay the escape letter and digits as they came
  function automatic void flush_held();
    for (int i = 0; i <= int'(ndig); i++) due_word(held[i], 1'b0);
    mode    = PM_TEXT;
    odd_run = 1'b0;
    ndig    = '0;
    acc     = '0;
  endfunction

  function automatic void translate_byte(input logic [7:0] b, input logic last);
    int v;
    int n_before;
    logic [3:0] need;
    n_before = due_words.size();
    need = wide ? NEED_WIDE : NEED_NARROW;
    if (err_seen) begin
      if (last) due_word(8'h00, 1'b1);
    end else if (mode == PM_COMMENT) begin
      due_word(b, 1'b0);
      if (b == CH_RPAREN) mode = PM_TEXT;
    end else if (mode == PM_ESCAPE) begin
      v = hex_val(b);
      if (v < 0) begin
        flush_held();
        take_text(b);
      end else begin
        ndig       = ndig + 1'b1;
        held[ndig] = b;
        acc        = {acc[27:0], v[3:0]};
        if (ndig >= need) begin
          if (acc > CODE_LIMIT) begin
            err_seen = 1'b1;
            due_word(8'h00, 1'b1);
          end else begin
            due_word(CH_X, 1'b0);
            due_word(CH_OPEN, 1'b0);
            for (int i = 1; i <= int'(need); i++) due_word(held[i], 1'b0);
            due_word(CH_CLOSE, 1'b0);
            mode    = PM_TEXT;
            odd_run = 1'b0;
            ndig    = '0;
            acc     = '0;
          end
        end
      end
    end else begin
      take_text(b);
    end
    // end of pattern: short escape replays, last word marked, state back to reset
    if (last) begin
      if (!err_seen && mode == PM_ESCAPE) flush_held();
      if (due_words.size() > n_before) due_words[due_words.size() - 1].last = 1'b1;
      clear_state();
    end
  endfunction

  // sender
  always @(posedge clk) begin : drive
    in_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
      in_byte  <= 8'h00;
      in_last  <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pend_words.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        w = pend_words.pop_front();
        in_valid <= 1'b1;
        in_byte  <= w.b;
        in_last  <= w.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_done <= 0;
      hold_left <= 0;
    end else if (hold_ticket != hold_done) begin
      hold_done <= hold_ticket;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // predict on each accepted input word, then check each accepted output word
  always @(posedge clk) begin : monitor
    out_word_t w;
    if (rst) begin
      clear_state();
      due_words.delete();
    end else begin
      if (in_valid && !in_stall) translate_byte(in_byte, in_last);
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          $error("unexpected word: out_byte %0h out_last %0b range_error %0b",
                 out_byte, out_last, range_error);
          n_fail++;
        end else begin
          w = due_words.pop_front();
          if (out_byte !== w.b) begin
            $error("out_byte: expected %0h, got %0h", w.b, out_byte);
            n_fail++;
          end
          if (out_last !== w.last) begin
            $error("out_last: expected %0b, got %0b", w.last, out_last);
            n_fail++;
          end
          if (range_error !== w.err) begin
            $error("range_error: expected %0b, got %0b", w.err, range_error);
            n_fail++;
          end
        end
      end
    end
  end

  task automatic put_pattern(input logic [7:0] txt[$]);
    for (int i = 0; i < txt.size(); i++)
      pend_words.push_back('{b: txt[i], last: (i == txt.size() - 1)});
  endtask

  // wait for the sender to run dry and every due word to arrive
  task automatic settle();
    while (pend_words.size() != 0 || in_valid || due_words.size() != 0)
      @(negedge clk);
  endtask

  // mostly well-formed patterns with random content, some noise
  task automatic run_random_phase(input int n_items);
    logic [7:0] txt[$];
    logic [31:0] val;
    logic [7:0] junk;
    int pushed;
    int nd;
    int k;
    bit up;
    pushed = 0;
    while (pushed < n_items) begin
      txt.delete();
      repeat ($urandom_range(1, 5)) begin
        k = $urandom_range(0, 99);
        if (k < 30) begin
          // escape after an odd backslash run, a wide one now and then above the limit
          repeat ($urandom_range(0, 1) * 2 + 1) txt.push_back(CH_BSLASH);
          up = 1'($urandom_range(0, 1));
          if (up) begin
            txt.push_back(CH_UP_U);
            nd = 8;
            if ($urandom_range(0, 19) == 0) val = $urandom_range(CODE_LIMIT + 1, 32'hFFFF_FFFF);
            else val = $urandom_range(0, CODE_LIMIT);
          end else begin
            txt.push_back(CH_LOW_U);
            nd = 4;
            val = $urandom;
          end
          for (int i = nd - 1; i >= 0; i--)
            txt.push_back(hex_char(val[i*4 +: 4], 1'($urandom_range(0, 1))));
        end else if (k < 40) begin
          // comment, possibly holding an escape, sometimes left open
          txt.push_back(CH_LPAREN);
          txt.push_back(CH_QMARK);
          txt.push_back(CH_HASH);
          if ($urandom_range(0, 1)) begin
            txt.push_back(CH_BSLASH);
            txt.push_back(CH_LOW_U);
          end
          repeat ($urandom_range(0, 4)) txt.push_back(8'($urandom_range(32, 126)));
          if ($urandom_range(0, 4) != 0) txt.push_back(CH_RPAREN);
        end else if (k < 50) begin
          // escape broken by a non-hex byte
          up = 1'($urandom_range(0, 1));
          txt.push_back(CH_BSLASH);
          txt.push_back(up ? CH_UP_U : CH_LOW_U);
          val = $urandom;
          repeat ($urandom_range(0, up ? 7 : 3))
            txt.push_back(hex_char(val[3:0] ^ 4'($urandom), 1'($urandom_range(0, 1))));
          case ($urandom_range(0, 3))
            0: junk = "g";
            1: junk = CH_BSLASH;
            2: junk = CH_LPAREN;
            default: junk = 8'($urandom_range(0, 47));
          endcase
          txt.push_back(junk);
        end else if (k < 58) begin
          // even backslash run: no translation
          txt.push_back(CH_BSLASH);
          txt.push_back(CH_BSLASH);
          txt.push_back(CH_LOW_U);
          val = $urandom;
          for (int i = 3; i >= 0; i--) txt.push_back(hex_char(val[i*4 +: 4], 1'b0));
        end else if (k < 80) begin
          repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom_range(32, 126)));
        end else begin
          repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(0, 255)));
        end
      end
      // pattern ending inside an escape
      if ($urandom_range(0, 9) == 0) begin
        txt.push_back(CH_BSLASH);
        txt.push_back($urandom_range(0, 1) ? CH_UP_U : CH_LOW_U);
        repeat ($urandom_range(0, 3)) txt.push_back(hex_char(4'($urandom), 1'b1));
      end
      put_pattern(txt);
      pushed += txt.size();
    end
  endtask

  initial begin
    logic [7:0] txt[$];
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: narrow escape, wide escape above the limit, dropped bytes
    txt = '{CH_BSLASH, CH_LOW_U, "0", "a", "F", "9",
            CH_BSLASH, CH_UP_U, "0", "0", "1", "1", "0", "0", "0", "0",
            8'h00, 8'hFF};
    put_pattern(txt);
    // failed escape, then a wide escape cut short by the end of the pattern
    txt = '{CH_BSLASH, CH_LOW_U, CH_BSLASH, CH_UP_U, "1"};
    put_pattern(txt);
    // escaped paren opening a comment that never closes
    txt = '{CH_BSLASH, CH_LPAREN, CH_QMARK, CH_HASH, CH_BSLASH, CH_LOW_U};
    put_pattern(txt);
    settle();

    run_random_phase(55);
    settle();

    send_gap_pct   = 54;
    recv_stall_pct = 35;
    run_random_phase(55);
    settle();

    // no idling; long receiver hold-off while the sender keeps offering
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_random_phase(35);
    hold_ticket = hold_ticket + 1;
    settle();

    repeat (DRAIN_LEN) @(negedge clk);
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ute_pkg.sv
design/ute_ctrl.sv
design/ute_dp.sv
design/unicode_escape_translator_top.sv
dv/unicode_escape_translator_top_tb.sv
